@@ hdl/lrast_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Beat structs for the input and result channels, command codes, field widths.
// No dependencies.
package lrast_pkg;

  localparam int unsigned FIELD_COORD_W = 12;
  localparam int unsigned OFFSET_W      = 24;
  localparam int unsigned PITCH_W       = 13;
  localparam int unsigned COUNT_W       = 13;
  localparam int unsigned COLOR_W       = 32;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [FIELD_COORD_W-1:0] start_x;
    logic [FIELD_COORD_W-1:0] start_y;
    logic [FIELD_COORD_W-1:0] end_x;
    logic [FIELD_COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]       line_color;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_x;
    logic [FIELD_COORD_W-1:0] pixel_y;
    logic [OFFSET_W-1:0]      pixel_offset;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     last_pixel;
  } out_beat_t;

  // Status from the core back to the input stage and the top level.
  typedef struct packed {
    logic advance;   // result register can take a new beat this cycle
    logic active;    // a line is in progress
  } core_stat_t;

endpackage

@@ hdl/line_rasterizer_unit.sv @@
// Top level of the line rasterizer: configuration register, input stage, core.
// Instantiates lrast_in_stage and lrast_core; depends on lrast_pkg.
//
// Bresenham line rasterizer with a valid/stall input and result channel. A start
// beat (cmd = start) latches both endpoints and the color and gives no pixel; it
// restarts the line even when one is in progress. Each step beat then gives one
// pixel beat with x, y, the word offset y * line_pitch + x (mod 2^24) and the
// color; the last of major delta + 1 pixels carries last_pixel. A step beat with
// no line in progress gives nothing. The block takes one beat per clock while no
// result beat is held by out_stall: the input register feeds the core, whose setup
// decode or pixel step (one 13-bit by COORD_BITS multiply plus add, and the error
// add and compare) is combinational into the result register. A pixel beat passes
// the input register and then the result register before it is on the outputs.
// in_stall rises only while a result beat is held by out_stall and the input
// register is full. Write line_pitch only while no beat is in flight.
module line_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lrast_pkg::in_beat_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lrast_pkg::out_beat_t          out_data,
  input  logic                          cfg_we,
  input  logic [lrast_pkg::PITCH_W-1:0] cfg_wdata
);

  logic [lrast_pkg::PITCH_W-1:0] pitch_r;
  logic [lrast_pkg::PITCH_W-1:0] pitch_nxt;

  logic                  item_valid;
  lrast_pkg::in_beat_t   item;
  lrast_pkg::core_stat_t stat;

  // Pitch register: take every write, any value including zero is used as given.
  assign pitch_nxt = cfg_we ? cfg_wdata : pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= lrast_pkg::PITCH_RESET;
    end else begin
      pitch_r <= pitch_nxt;
    end
  end

  // Input register: hold the beat while the result side is blocked.
  lrast_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .stat       (stat),
    .item_valid (item_valid),
    .item       (item)
  );

  // Core: setup decode, error stepping, offset multiply, result register.
  lrast_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .pitch      (pitch_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .stat       (stat)
  );

  // A start beat moving into the core never leaves a pixel behind it.
  a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && stat.advance && (item.cmd == lrast_pkg::CMD_START) |=> !out_valid)
    else $error("start beat produced a pixel");

  // A step beat with no line in progress never leaves a pixel behind it.
  a_idle_step_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && stat.advance && (item.cmd == lrast_pkg::CMD_STEP) && !stat.active
    |=> !out_valid)
    else $error("idle step produced a pixel");

  // Back-pressure toward the input only comes from a held result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // The final pixel of a line ends it.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && stat.advance && (item.cmd == lrast_pkg::CMD_STEP) && stat.active
    ##1 out_data.last_pixel |-> !stat.active)
    else $error("line still active after last pixel");

endmodule

@@ hdl/lrast_in_stage.sv @@
// Input register stage of the line rasterizer.
// Captures one input beat and holds it while the core cannot advance.
// Depends on lrast_pkg.
module lrast_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrast_pkg::in_beat_t  in_data,
  input  lrast_pkg::core_stat_t stat,
  output logic                 item_valid,
  output lrast_pkg::in_beat_t  item
);

  logic                valid_r;
  logic                valid_nxt;
  lrast_pkg::in_beat_t item_r;

  // Hold the captured beat only while the core is blocked by a stalled result.
  assign in_stall  = valid_r && !stat.advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hdl/lrast_core.sv @@
// Line state, setup decode, pixel step and result register.
// Takes a registered input beat, emits at most one pixel beat per clock.
// Depends on lrast_pkg.
module lrast_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  lrast_pkg::in_beat_t         item,
  input  logic [lrast_pkg::PITCH_W-1:0] pitch,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lrast_pkg::out_beat_t        out_data,
  output lrast_pkg::core_stat_t       stat
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned ERR_W = COORD_BITS + 4;
  localparam int unsigned CMP_W = (CB > lrast_pkg::COUNT_W) ? CB : lrast_pkg::COUNT_W;
  localparam int unsigned PROD_W = CB + lrast_pkg::PITCH_W;

  logic                 active_r,    active_nxt;
  logic [CB-1:0]        cur_x_r,     cur_x_nxt;
  logic [CB-1:0]        cur_y_r,     cur_y_nxt;
  logic [CB-1:0]        major_r,     major_nxt;
  logic [CB-1:0]        minor_r,     minor_nxt;
  logic signed [ERR_W-1:0] err_r,    err_nxt;
  logic [lrast_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                 x_major_r,   x_major_nxt;
  logic                 major_neg_r, major_neg_nxt;
  logic                 minor_neg_r, minor_neg_nxt;
  logic [lrast_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lrast_pkg::out_beat_t out_r,       out_nxt;

  logic                 advance;
  logic                 fire;

  // setup decode
  logic [CB-1:0] sx, sy, ex, ey, dx, dy;
  logic          xneg, yneg;

  // step datapath
  logic [PROD_W-1:0]       prod;
  logic signed [ERR_W-1:0] minor4, major4, err_add;
  logic                    last;
  logic [CB-1:0]           x_minor, y_minor;

  function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] c, input logic neg);
    step_coord = neg ? c - 1'b1 : c + 1'b1;
  endfunction

  assign advance = !out_valid_r || !out_stall;
  assign fire    = item_valid && advance;

  assign sx   = CB'(item.start_x);
  assign sy   = CB'(item.start_y);
  assign ex   = CB'(item.end_x);
  assign ey   = CB'(item.end_y);
  assign xneg = ex < sx;
  assign yneg = ey < sy;
  assign dx   = xneg ? sx - ex : ex - sx;
  assign dy   = yneg ? sy - ey : ey - sy;

  assign prod    = cur_y_r * pitch;
  assign minor4  = $signed({2'b00, minor_r, 2'b00});
  assign major4  = $signed({2'b00, major_r, 2'b00});
  assign err_add = err_r + minor4;
  assign last    = CMP_W'(count_r) >= CMP_W'(major_r);

  always_comb begin
    active_nxt    = active_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    err_nxt       = err_r;
    count_nxt     = count_r;
    x_major_nxt   = x_major_r;
    major_neg_nxt = major_neg_r;
    minor_neg_nxt = minor_neg_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    x_minor       = cur_x_r;
    y_minor       = cur_y_r;

    if (fire) begin
      case (item.cmd)
        lrast_pkg::CMD_START: begin
          cur_x_nxt = sx;
          cur_y_nxt = sy;
          if (dx < dy) begin
            x_major_nxt   = 1'b0;
            major_nxt     = dy;
            minor_nxt     = dx;
            major_neg_nxt = yneg;
            minor_neg_nxt = xneg;
          end else begin
            x_major_nxt   = 1'b1;
            major_nxt     = dx;
            minor_nxt     = dy;
            major_neg_nxt = xneg;
            minor_neg_nxt = yneg;
          end
          err_nxt    = '0;
          count_nxt  = '0;
          color_nxt  = item.line_color;
          active_nxt = 1'b1;
        end
        lrast_pkg::CMD_STEP: begin
          if (active_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt.pixel_x      = lrast_pkg::FIELD_COORD_W'(cur_x_r);
            out_nxt.pixel_y      = lrast_pkg::FIELD_COORD_W'(cur_y_r);
            out_nxt.pixel_offset = lrast_pkg::OFFSET_W'(prod)
                                 + lrast_pkg::OFFSET_W'(cur_x_r);
            out_nxt.pixel_color  = color_r;
            out_nxt.last_pixel   = last;

            // Advance the error, take a minor step when it turns positive.
            err_nxt = err_add;
            if (err_add > 0) begin
              err_nxt = err_add - major4;
              if (x_major_r) begin
                y_minor = step_coord(cur_y_r, minor_neg_r);
              end else begin
                x_minor = step_coord(cur_x_r, minor_neg_r);
              end
            end
            if (x_major_r) begin
              cur_x_nxt = step_coord(cur_x_r, major_neg_r);
              cur_y_nxt = y_minor;
            end else begin
              cur_x_nxt = x_minor;
              cur_y_nxt = step_coord(cur_y_r, major_neg_r);
            end
            count_nxt = count_r + 1'b1;
            if (last) begin
              active_nxt = 1'b0;
            end
          end
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      err_r       <= '0;
      count_r     <= '0;
      x_major_r   <= 1'b1;
      major_neg_r <= 1'b0;
      minor_neg_r <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      err_r       <= err_nxt;
      count_r     <= count_nxt;
      x_major_r   <= x_major_nxt;
      major_neg_r <= major_neg_nxt;
      minor_neg_r <= minor_neg_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign stat.advance = advance;
  assign stat.active  = active_r;

endmodule
